// ----- hw/rtl/chgw_pkg.sv -----
// ----------------------------------------------------------------------------
// chgw_pkg: shared types for the gift-wrap convex hull block
// Holds the sequencer state encoding used by the hull top level.
// ----------------------------------------------------------------------------
package chgw_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEW,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_CUR_RD,
        ST_CUR_LAT,
        ST_CAND_RD,
        ST_CAND_DIFF,
        ST_CAND_MUL,
        ST_CAND_DEC,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/chgw_ram.sv -----
// ----------------------------------------------------------------------------
// chgw_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module chgw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/convex_hull_gift_wrap_top.sv -----
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap_top: convex hull by gift wrapping over loaded points
// Stores points in two coordinate RAMs, then walks the hull counterclockwise
// and emits the load-order index of each hull point.
// ----------------------------------------------------------------------------
// Usage: load one point per cycle while busy is low (start high). A point
// with final_point set closes the set and raises busy for the walk. Results
// come out as single-cycle strobes on hull_valid and cannot be held off; the
// word with hull_last set ends the set, and busy is already low when it
// appears. Finding the leftmost start point reads and compares each stored
// point in turn; each hull point reads its own coordinates, then every candidate
// goes through a read of the coordinate RAMs, a difference stage, a
// cross-product multiply stage and a decision stage before the next one may
// use the updated pick. A set with fewer than three points gives one word
// with too_few set, by way of the ST_FEW state. Points beyond MAX_POINTS are
// dropped.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap_top
    import chgw_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         px,
    input  logic [COORD_BITS-1:0]         py,
    input  logic                          final_point,
    output logic                          hull_valid,
    output logic [$clog2(MAX_POINTS)-1:0] hull_index,
    output logic                          hull_last,
    output logic                          too_few
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic          have_reg, have_next;
    logic          hull_valid_reg, hull_valid_next;

    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic signed [COORD_BITS-1:0] minx_reg, minx_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic signed [DW-1:0] pdx_reg, pdx_next;
    logic signed [DW-1:0] pdy_reg, pdy_next;
    logic signed [PW-1:0] m1_reg, m1_next;
    logic signed [PW-1:0] m2_reg, m2_next;
    logic [IW-1:0] hull_index_reg, hull_index_next;
    logic          hull_last_reg, hull_last_next;
    logic          too_few_reg, too_few_next;

    logic          accept;
    logic          store_ok;
    logic [CW-1:0] n_load;
    logic          last_i;
    logic          walk_done;

    logic                  ram_we;
    logic [IW-1:0]         ram_raddr;
    logic [COORD_BITS-1:0] x_rdata;
    logic [COORD_BITS-1:0] y_rdata;

    logic          coinc;
    logic          same_dir;
    logic          take;
    logic [DW-1:0] dx_mag, dy_mag, pdx_mag, pdy_mag;
    logic [DW:0]   d_sum, p_sum;

    // ------------------------------------------------------------------
    // Point storage
    // ------------------------------------------------------------------
    chgw_ram #(
        .WIDTH(COORD_BITS),
        .DEPTH(MAX_POINTS)
    ) u_x_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IW-1:0]),
        .wdata(px),
        .raddr(ram_raddr),
        .rdata(x_rdata)
    );

    chgw_ram #(
        .WIDTH(COORD_BITS),
        .DEPTH(MAX_POINTS)
    ) u_y_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IW-1:0]),
        .wdata(py),
        .raddr(ram_raddr),
        .rdata(y_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign store_ok  = (count_reg < CW'(MAX_POINTS));
    assign ram_we    = accept && store_ok;
    assign n_load    = store_ok ? (count_reg + CW'(1)) : count_reg;
    assign ram_raddr = (state_reg == ST_CUR_RD) ? cur_reg : i_reg;
    assign last_i    = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign walk_done = !have_reg || (pick_reg == start_reg) ||
                       ((k_reg + CW'(1)) >= count_reg);

    // ------------------------------------------------------------------
    // Candidate decision: take the first candidate that is not on the current point; then replace
    // the pick when the candidate is clockwise of it, or collinear in the same direction and farther out.
    // ------------------------------------------------------------------
    always_comb
    begin
        dx_mag   = dx_reg[DW-1]  ? DW'(-dx_reg)  : DW'(dx_reg);
        dy_mag   = dy_reg[DW-1]  ? DW'(-dy_reg)  : DW'(dy_reg);
        pdx_mag  = pdx_reg[DW-1] ? DW'(-pdx_reg) : DW'(pdx_reg);
        pdy_mag  = pdy_reg[DW-1] ? DW'(-pdy_reg) : DW'(pdy_reg);
        d_sum    = {1'b0, dx_mag} + {1'b0, dy_mag};
        p_sum    = {1'b0, pdx_mag} + {1'b0, pdy_mag};
        coinc    = (dx_reg == '0) && (dy_reg == '0);
        same_dir = ((dx_reg == '0) == (pdx_reg == '0)) && (dx_reg[DW-1] == pdx_reg[DW-1]) &&
                   ((dy_reg == '0) == (pdy_reg == '0)) && (dy_reg[DW-1] == pdy_reg[DW-1]);
        take = 1'b0;
        if (!coinc)
        begin
            if (!have_reg)
            begin
                take = 1'b1;
            end
            else if (m1_reg < m2_reg)
            begin
                take = 1'b1;
            end
            else if ((m1_reg == m2_reg) && same_dir)
            begin
                // the start point always wins a collinear tie so the walk closes
                if (i_reg == start_reg)
                begin
                    take = 1'b1;
                end
                else if ((pick_reg != start_reg) && (d_sum > p_sum))
                begin
                    take = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && final_point)
                begin
                    state_next = (n_load < CW'(3)) ? ST_FEW : ST_MIN_RD;
                end
            end
            ST_FEW:       state_next = ST_IDLE;
            ST_MIN_RD:    state_next = ST_MIN_CMP;
            ST_MIN_CMP:   state_next = last_i ? ST_CUR_RD : ST_MIN_RD;
            ST_CUR_RD:    state_next = ST_CUR_LAT;
            ST_CUR_LAT:   state_next = ST_CAND_RD;
            ST_CAND_RD:   state_next = ST_CAND_DIFF;
            ST_CAND_DIFF: state_next = ST_CAND_MUL;
            ST_CAND_MUL:  state_next = ST_CAND_DEC;
            ST_CAND_DEC:  state_next = last_i ? ST_EMIT : ST_CAND_RD;
            ST_EMIT:      state_next = walk_done ? ST_IDLE : ST_CUR_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        have_next       = have_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        pick_next       = pick_reg;
        minx_next       = minx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        pdx_next        = pdx_reg;
        pdy_next        = pdy_reg;
        m1_next         = m1_reg;
        m2_next         = m2_reg;
        hull_valid_next = 1'b0;
        hull_index_next = hull_index_reg;
        hull_last_next  = hull_last_reg;
        too_few_next    = too_few_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = n_load;
                    i_next     = '0;
                end
            end
            ST_FEW:
            begin
                hull_valid_next = 1'b1;
                hull_index_next = '0;
                hull_last_next  = 1'b1;
                too_few_next    = 1'b1;
                count_next      = '0;
            end
            ST_MIN_RD:
            begin
            end
            ST_MIN_CMP:
            begin
                // keep the first point with the least x
                if ((i_reg == '0) || ($signed(x_rdata) < minx_reg))
                begin
                    minx_next  = $signed(x_rdata);
                    start_next = i_reg;
                end
                if (last_i)
                begin
                    cur_next = ((i_reg == '0) || ($signed(x_rdata) < minx_reg)) ?
                               i_reg : start_reg;
                    k_next   = '0;
                    i_next   = '0;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_CUR_RD:
            begin
            end
            ST_CUR_LAT:
            begin
                cx_next   = $signed(x_rdata);
                cy_next   = $signed(y_rdata);
                have_next = 1'b0;
                i_next    = '0;
            end
            ST_CAND_RD:
            begin
            end
            ST_CAND_DIFF:
            begin
                dx_next = $signed({x_rdata[COORD_BITS-1], x_rdata}) -
                          $signed({cx_reg[COORD_BITS-1], cx_reg});
                dy_next = $signed({y_rdata[COORD_BITS-1], y_rdata}) -
                          $signed({cy_reg[COORD_BITS-1], cy_reg});
            end
            ST_CAND_MUL:
            begin
                m1_next = pdx_reg * dy_reg;
                m2_next = pdy_reg * dx_reg;
            end
            ST_CAND_DEC:
            begin
                if (take)
                begin
                    pick_next = i_reg;
                    pdx_next  = dx_reg;
                    pdy_next  = dy_reg;
                    have_next = 1'b1;
                end
                if (!last_i)
                begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_EMIT:
            begin
                hull_valid_next = 1'b1;
                hull_index_next = cur_reg;
                hull_last_next  = walk_done;
                too_few_next    = 1'b0;
                if (walk_done)
                begin
                    count_next = '0;
                end
                else
                begin
                    cur_next = pick_reg;
                    k_next   = k_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            have_reg       <= 1'b0;
            hull_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            have_reg       <= have_next;
            hull_valid_reg <= hull_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        cur_reg        <= cur_next;
        pick_reg       <= pick_next;
        minx_reg       <= minx_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        pdx_reg        <= pdx_next;
        pdy_reg        <= pdy_next;
        m1_reg         <= m1_next;
        m2_reg         <= m2_next;
        hull_index_reg <= hull_index_next;
        hull_last_reg  <= hull_last_next;
        too_few_reg    <= too_few_next;
    end

    assign hull_valid = hull_valid_reg;
    assign hull_index = hull_index_reg;
    assign hull_last  = hull_last_reg;
    assign too_few    = too_few_reg;

`ifndef SYNTHESIS
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid |-> ($past(state_reg) == ST_EMIT || $past(state_reg) == ST_FEW))
        else $error("result strobe without an emit state");

    a_few_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (hull_valid && too_few) |-> hull_last)
        else $error("too_few word not marked last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_cand_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAND_DEC) |-> (CW'(i_reg) < count_reg))
        else $error("candidate index outside loaded set");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && walk_done) |=> !busy)
        else $error("walk did not end after last hull word");
`endif

endmodule
